// File: rtl/bounded_deque_store_defines.svh
// assertion macros for the bounded deque store
`ifndef BOUNDED_DEQUE_STORE_DEFINES_SVH
`define BOUNDED_DEQUE_STORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bds_pkg.sv
// shared constants and codes for the bounded deque store
package bds_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int TDATA_W  = 48;

    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

// File: rtl/bounded_deque_store.sv
// bounded deque store: circular buffer of DEPTH words with front pointer and count
// a result is registered and appears in the cycle after its item is accepted
// one item per cycle unless a result stalls; at most one write or read per item
// a result held by back-pressure keeps s_tready low until it is taken
// reset clears front pointer, count and result valid; store contents stay undefined
module bounded_deque_store #(
    parameter int DEPTH = bds_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // func [2:0], value [34:3], position [44:35], zero fill above
    input  logic [bds_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // read_data [31:0], status [33:32], count_now [44:34], zero fill above
    output logic [bds_pkg::TDATA_W-1:0]  m_tdata
);

    `include "bounded_deque_store_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + bds_pkg::POS_W + 1;
    localparam int CMP_W = CNT_W + bds_pkg::POS_W;
    localparam int OUT_W = bds_pkg::VALUE_W + bds_pkg::STATUS_W + bds_pkg::COUNT_W;

    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [bds_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [bds_pkg::COUNT_W-1:0]  count_out_reg;
    logic             rd_ok_reg;

    logic [bds_pkg::FUNC_W-1:0]  func;
    logic signed [bds_pkg::VALUE_W-1:0] value;
    logic [bds_pkg::POS_W-1:0]   position;

    logic             accept;
    logic             full, empty, in_range;
    logic             push_taken;
    logic [SUM_W-1:0] back_sum, read_sum;
    logic [PTR_W-1:0] back_slot, read_slot, prev_slot, succ_slot;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr;
    logic [bds_pkg::VALUE_W-1:0] ram_q;
    logic [CNT_W+bds_pkg::COUNT_W-1:0] count_wide;
    logic signed [bds_pkg::VALUE_W-1:0] read_data;

    assign func     = s_tdata[2:0];
    assign value    = s_tdata[34:3];
    assign position = s_tdata[44:35];

    assign accept = s_tvalid & s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign in_range = ({{bds_pkg::POS_W{1'b0}}, count_reg} > {{CNT_W{1'b0}}, position});

    // slot of front + offset, offset always below DEPTH where it is used
    assign back_sum = {{(bds_pkg::POS_W + 1){1'b0}}, front_reg}
                    + SUM_W'(count_reg);
    assign read_sum = {{(bds_pkg::POS_W + 1){1'b0}}, front_reg}
                    + {{(PTR_W + 1){1'b0}}, position};
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                   : back_sum[PTR_W-1:0];
    assign read_slot = (read_sum >= SUM_W'(DEPTH)) ? PTR_W'(read_sum - SUM_W'(DEPTH))
                                                   : read_sum[PTR_W-1:0];
    assign prev_slot = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign succ_slot = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = bds_pkg::ST_OK;
        wr_en       = 1'b0;
        wr_addr     = back_slot;
        rd_en       = 1'b0;
        case (func)
            bds_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    status_next = bds_pkg::ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bds_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status_next = bds_pkg::ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = prev_slot;
                    front_next = prev_slot;
                    count_next = count_reg + 1'b1;
                end
            end
            bds_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status_next = bds_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            bds_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status_next = bds_pkg::ST_EMPTY;
                end else begin
                    front_next = succ_slot;
                    count_next = count_reg - 1'b1;
                end
            end
            bds_pkg::OP_READ: begin
                if (in_range) begin
                    rd_en = 1'b1;
                end else begin
                    status_next = bds_pkg::ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = accept || (m_valid_reg && !m_tready);
    assign count_wide   = {{bds_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            count_out_reg <= count_wide[bds_pkg::COUNT_W-1:0];
            rd_ok_reg     <= rd_en;
        end
    end

    // read data register only moves on accept, so it holds while the result stalls
    bds_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (bds_pkg::VALUE_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && accept),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en && accept),
        .rd_addr (read_slot),
        .rd_data (ram_q)
    );

    assign read_data = rd_ok_reg ? ram_q : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(bds_pkg::TDATA_W - OUT_W){1'b0}},
                       count_out_reg, status_reg, read_data};

    assign push_taken = accept && !full
                     && ((func == bds_pkg::OP_PUSH_BACK) || (func == bds_pkg::OP_PUSH_FRONT));

    `BDS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count past capacity")
    `BDS_ASSERT_NOW(a_front_bound, 1'b1, front_reg <= PTR_W'(DEPTH - 1),
        "front pointer out of range")
    `BDS_ASSERT_NEXT(a_push_grows, push_taken, count_reg == $past(count_reg) + 1'b1,
        "push did not grow count")
    `BDS_ASSERT_NOW(a_read_ok, m_valid_reg && rd_ok_reg, status_reg == bds_pkg::ST_OK,
        "read data with bad status")
    `BDS_ASSERT_NOW(a_stall_cause, !s_tready, m_valid_reg && !m_tready,
        "input stalled without a waiting result")

endmodule

// File: rtl/bds_ram.sv
// element store: one write port, one registered read port
module bds_ram #(
    parameter int DEPTH  = bds_pkg::DEPTH_DEFAULT,
    parameter int DATA_W = bds_pkg::VALUE_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
